@@ rtl/mps_pkg.sv @@
// mps_pkg: shared types and constants of the migration pair selector
// used by mps_search and migration_pair_selector_core; no dependencies
`default_nettype none

package mps_pkg;

  localparam int IDX_W = 12;
  localparam int POP_W = 13;
  localparam int PCT_W = 7;
  localparam int FIT_W = 32;
  localparam int KIND_W = 2;

  localparam int PCT_SCALE = 100;

  localparam logic [POP_W-1:0] POP_RESET = 13'd4096;
  localparam logic [PCT_W-1:0] PCT_RESET = 7'd30;
  localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;

  localparam logic [KIND_W-1:0] KIND_LOAD_A = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOAD_B = 2'd1;
  localparam logic [KIND_W-1:0] KIND_NEXT = 2'd2;

  localparam logic REG_POP_COUNT = 1'b0;
  localparam logic REG_PERCENT = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_MARK,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic clear;
    logic start;
    logic hit;
    logic mark;
  } search_ctl_t;

endpackage

`default_nettype wire

@@ rtl/mps_search.sv @@
// mps_search: one best or worst search with its own taken-mark memory
// depends on mps_pkg; fed keys by migration_pair_selector_core
`default_nettype none

module mps_search #(
  parameter int MAX_POP = 4096,
  parameter int KEY_WIDTH = 32,
  parameter bit WANT_MAX = 1'b0
) (
  input  logic                       clk,
  input  logic                       rst,
  input  mps_pkg::search_ctl_t       ctl,
  input  logic [$clog2(MAX_POP)-1:0] addr,
  input  logic [$clog2(MAX_POP)-1:0] hit_idx,
  input  logic [KEY_WIDTH-1:0]       key,
  output logic                       found,
  output logic [$clog2(MAX_POP)-1:0] best_idx
);
  import mps_pkg::*;

  logic                 taken [MAX_POP];
  logic                 taken_q;
  logic [KEY_WIDTH-1:0] best_key;
  logic                 better;

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      taken[addr] <= 1'b0;
    end else if (ctl.mark && found) begin
      taken[best_idx] <= 1'b1;
    end
    taken_q <= taken[addr];
  end

  always_comb begin
    if (WANT_MAX) begin
      better = $signed(key) > $signed(best_key);
    end else begin
      better = $signed(key) < $signed(best_key);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (ctl.start) begin
      found <= 1'b0;
    end else if (ctl.hit && !taken_q && (!found || better)) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.hit && !taken_q && (!found || better)) begin
      best_idx <= hit_idx;
      best_key <= key;
    end
  end

endmodule

`default_nettype wire

@@ rtl/migration_pair_selector_core.sv @@
// migration_pair_selector_core: key memories, sequencer and four pair searches
// depends on mps_pkg and mps_search
//
//   channel  direction  handshake            payload
//   in       in         in_valid / in_stall  kind, entry_index, fitness_key
//   out      out        out_valid/out_stall  valid_res, four indices, last
//   config   in         wr_en                wr_index, wr_data
//
// a load writes its key memory on acceptance; the first load after pairs were
// picked adds a pass over all MAX_POP taken marks that clears them, and reset
// starts with the same pass; a next beat with a pair left scans n entries, n being
// pop_count held to 1..MAX_POP: one key read per cycle from each key memory feeds all
// four searches, then the picks are marked; an exhausted next skips the scan
// input is stalled until a beat's result is registered; a held result blocks no loads
`default_nettype none

module migration_pair_selector_core #(
  parameter int MAX_POP = 4096,
  parameter int KEY_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [mps_pkg::KIND_W-1:0]  kind,
  input  logic [mps_pkg::IDX_W-1:0]   entry_index,
  input  logic signed [mps_pkg::FIT_W-1:0] fitness_key,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        valid_res,
  output logic [mps_pkg::IDX_W-1:0]   a_best_index,
  output logic [mps_pkg::IDX_W-1:0]   b_worst_index,
  output logic [mps_pkg::IDX_W-1:0]   b_best_index,
  output logic [mps_pkg::IDX_W-1:0]   a_worst_index,
  output logic                        last,
  input  logic                        wr_en,
  input  logic                        wr_index,
  input  logic [mps_pkg::POP_W-1:0]   wr_data
);
  import mps_pkg::*;

  localparam int IW = $clog2(MAX_POP);
  localparam int CW = $clog2(MAX_POP + 1);
  localparam int NW = (CW > POP_W) ? CW : POP_W;
  localparam int PW = CW + PCT_W;

  state_t state, state_next;

  logic [POP_W-1:0] pop_count;
  logic [PCT_W-1:0] percent_exchanged;

  logic [KEY_WIDTH-1:0] keys_a [MAX_POP];
  logic [KEY_WIDTH-1:0] keys_b [MAX_POP];
  logic [KEY_WIDTH-1:0] ka_q;
  logic [KEY_WIDTH-1:0] kb_q;

  logic [CW-1:0] cnt;
  logic [CW-1:0] pairs;
  logic [IW-1:0] hit_idx;
  logic          hit;
  logic          dirty;
  logic          res_ok;
  logic          last_r;
  logic [PW-1:0] prod;

  logic [NW-1:0]    pc_w;
  logic [NW-1:0]    n_w;
  logic [CW-1:0]    n_eff;
  logic [PCT_W-1:0] pct_eff;
  logic             avail;
  logic             last_next;
  logic             issue;
  logic             clear_done;
  logic             accept;
  logic             is_load;
  logic             load_ok;
  logic             out_load;
  logic [31:0]      idx32;
  logic [63:0]      key_ext;
  logic [KEY_WIDTH-1:0] key_in;
  logic [IW-1:0]    wr_addr;
  logic [IW-1:0]    scan_addr;

  search_ctl_t   ctl;
  logic          ab_found, bw_found, bb_found, aw_found;
  logic [IW-1:0] ab_idx, bw_idx, bb_idx, aw_idx;

  function automatic logic [IDX_W-1:0] to_port(input logic ok, input logic [IW-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return ok ? w[IDX_W-1:0] : '0;
  endfunction

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      pop_count         <= POP_RESET;
      percent_exchanged <= PCT_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_POP_COUNT: pop_count <= wr_data;
        REG_PERCENT:   percent_exchanged <= wr_data[PCT_W-1:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    pc_w = NW'(pop_count);
    if (pc_w == '0) begin
      n_w = NW'(1);
    end else if (pc_w > NW'(MAX_POP)) begin
      n_w = NW'(MAX_POP);
    end else begin
      n_w = pc_w;
    end
    n_eff   = n_w[CW-1:0];
    pct_eff = (percent_exchanged > PCT_MAX) ? PCT_MAX : percent_exchanged;
  end

  always_ff @(posedge clk) begin
    prod <= PW'(n_eff) * PW'(pct_eff);
  end

  // pairs_emitted < amount  <=>  100 * (pairs + 1) <= n * pct
  assign avail     = ((PW'(pairs) + PW'(1)) * PW'(PCT_SCALE)) <= prod;
  assign last_next = ((PW'(pairs) + PW'(2)) * PW'(PCT_SCALE)) > prod;

  // input beat decode
  assign accept  = in_valid && !in_stall;
  assign is_load = (kind == KIND_LOAD_A) || (kind == KIND_LOAD_B);
  assign idx32   = 32'(entry_index);
  assign load_ok = is_load && (idx32 < 32'(MAX_POP));
  assign wr_addr = idx32[IW-1:0];
  assign key_ext = {{(64 - FIT_W){fitness_key[FIT_W-1]}}, fitness_key};
  assign key_in  = key_ext[KEY_WIDTH-1:0];

  // key memories
  assign scan_addr = cnt[IW-1:0];

  always_ff @(posedge clk) begin
    if (accept && load_ok && kind == KIND_LOAD_A) begin
      keys_a[wr_addr] <= key_in;
    end
    ka_q <= keys_a[scan_addr];
  end

  always_ff @(posedge clk) begin
    if (accept && load_ok && kind == KIND_LOAD_B) begin
      keys_b[wr_addr] <= key_in;
    end
    kb_q <= keys_b[scan_addr];
  end

  assign issue      = (state == ST_SCAN) && (cnt < n_eff);
  assign clear_done = cnt == CW'(MAX_POP - 1);
  assign out_load   = (state == ST_DONE) && (!out_valid || !out_stall);

  always_comb begin
    ctl.clear = state == ST_CLEAR;
    ctl.start = (state == ST_CHECK) && avail;
    ctl.hit   = hit;
    ctl.mark  = state == ST_MARK;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    unique case (state)
      ST_CLEAR: begin
        if (clear_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (kind == KIND_NEXT) begin
            state_next = ST_CHECK;
          end else if (load_ok && dirty) begin
            state_next = ST_CLEAR;
          end
        end
      end
      ST_CHECK: begin
        state_next = avail ? ST_SCAN : ST_DONE;
      end
      ST_SCAN: begin
        if (!issue && !hit) begin
          state_next = ST_MARK;
        end
      end
      ST_MARK: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= '0;
      hit    <= 1'b0;
      pairs  <= '0;
      dirty  <= 1'b0;
      res_ok <= 1'b0;
      last_r <= 1'b0;
    end else begin
      hit <= issue;
      case (state)
        ST_CLEAR: begin
          cnt <= cnt + CW'(1);
        end
        ST_IDLE: begin
          if (accept && load_ok) begin
            pairs <= '0;
            if (dirty) begin
              dirty <= 1'b0;
              cnt   <= '0;
            end
          end
        end
        ST_CHECK: begin
          cnt    <= '0;
          res_ok <= 1'b0;
          last_r <= 1'b0;
        end
        ST_SCAN: begin
          if (issue) begin
            cnt <= cnt + CW'(1);
          end
        end
        ST_MARK: begin
          pairs  <= pairs + CW'(1);
          dirty  <= 1'b1;
          res_ok <= 1'b1;
          last_r <= last_next;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    hit_idx <= scan_addr;
  end

  // searches
  mps_search #(.MAX_POP(MAX_POP), .KEY_WIDTH(KEY_WIDTH), .WANT_MAX(1'b0)) u_a_best (
    .clk(clk), .rst(rst), .ctl(ctl), .addr(scan_addr), .hit_idx(hit_idx),
    .key(ka_q), .found(ab_found), .best_idx(ab_idx)
  );

  mps_search #(.MAX_POP(MAX_POP), .KEY_WIDTH(KEY_WIDTH), .WANT_MAX(1'b1)) u_b_worst (
    .clk(clk), .rst(rst), .ctl(ctl), .addr(scan_addr), .hit_idx(hit_idx),
    .key(kb_q), .found(bw_found), .best_idx(bw_idx)
  );

  mps_search #(.MAX_POP(MAX_POP), .KEY_WIDTH(KEY_WIDTH), .WANT_MAX(1'b0)) u_b_best (
    .clk(clk), .rst(rst), .ctl(ctl), .addr(scan_addr), .hit_idx(hit_idx),
    .key(kb_q), .found(bb_found), .best_idx(bb_idx)
  );

  mps_search #(.MAX_POP(MAX_POP), .KEY_WIDTH(KEY_WIDTH), .WANT_MAX(1'b1)) u_a_worst (
    .clk(clk), .rst(rst), .ctl(ctl), .addr(scan_addr), .hit_idx(hit_idx),
    .key(ka_q), .found(aw_found), .best_idx(aw_idx)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      valid_res     <= res_ok;
      last          <= res_ok && last_r;
      a_best_index  <= to_port(res_ok && ab_found, ab_idx);
      b_worst_index <= to_port(res_ok && bw_found, bw_idx);
      b_best_index  <= to_port(res_ok && bb_found, bb_idx);
      a_worst_index <= to_port(res_ok && aw_found, aw_idx);
    end
  end

endmodule

`default_nettype wire
